// ----- sv/fresr_pkg.sv -----
// Types, constants and per-step datapath functions for the Fresnel reflectance pipeline.
package fresr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IDX_FRAC  = 13;
    localparam int VAL_W     = FRAC_BITS + 1;

    localparam logic [14:0] ONE    = 15'd16384;
    localparam logic [29:0] ONE_SQ = 30'd1 << (2 * FRAC_BITS);
    localparam logic [29:0] HALF   = 30'd8192;

    // One input transaction
    typedef struct packed {
        logic [14:0] cos_incident;
        logic [14:0] index_from;
        logic [14:0] index_to;
    } t_fresr_in;

    // One result transaction
    typedef struct packed {
        logic [14:0] reflectance;
        logic        total_reflection;
    } t_fresr_out;

    // Operands that ride along the pipeline
    typedef struct packed {
        logic [14:0] c;
        logic [14:0] n1;
        logic [14:0] n2;
        logic        tir;
    } t_side;

    // Digit-by-digit square root state (two radicand bits per step)
    typedef struct packed {
        logic [29:0] rad;
        logic [17:0] rem;
        logic [14:0] root;
    } t_sqrt;

    // Restoring division for the transmitted sine
    typedef struct packed {
        logic [14:0] rem;
        logic [13:0] dvd;
        logic [13:0] q;
    } t_dst;

    // Restoring division for an amplitude ratio
    typedef struct packed {
        logic [17:0] den;
        logic [17:0] rem;
        logic [14:0] q;
    } t_rat;

    function automatic t_sqrt sqrt_step(t_sqrt a);
        logic [17:0] r2;
        logic [17:0] trial;
        t_sqrt       b;
        r2    = {a.rem[15:0], a.rad[29:28]};
        trial = {1'b0, a.root, 2'b01};
        b.rad = {a.rad[27:0], 2'b00};
        if (r2 >= trial) begin
            b.rem  = r2 - trial;
            b.root = {a.root[13:0], 1'b1};
        end else begin
            b.rem  = r2;
            b.root = {a.root[13:0], 1'b0};
        end
        return b;
    endfunction

    function automatic t_dst dst_step(t_dst a, logic [14:0] n2);
        logic [15:0] r2;
        t_dst        b;
        r2    = {a.rem, a.dvd[13]};
        b.dvd = {a.dvd[12:0], 1'b0};
        if (r2 >= {1'b0, n2}) begin
            b.rem = 15'(r2 - {1'b0, n2});
            b.q   = {a.q[12:0], 1'b1};
        end else begin
            b.rem = r2[14:0];
            b.q   = {a.q[12:0], 1'b0};
        end
        return b;
    endfunction

    // The first quotient bit compares without shifting
    function automatic t_rat rat_step(t_rat a, logic shift);
        logic [18:0] r2;
        t_rat        b;
        r2    = shift ? {a.rem, 1'b0} : {1'b0, a.rem};
        b.den = a.den;
        if (r2 >= {1'b0, a.den}) begin
            b.rem = 18'(r2 - {1'b0, a.den});
            b.q   = {a.q[13:0], 1'b1};
        end else begin
            b.rem = r2[17:0];
            b.q   = {a.q[13:0], 1'b0};
        end
        return b;
    endfunction

endpackage

// ----- sv/fresnel_unpolarized_reflectance_unit.sv -----
// Fresnel reflectance for unpolarized light: 65-stage fixed-point pipeline.
//
// Input channel i_valid/o_stall carries cos_incident (Q1.14) and the two
// refractive indices (Q2.13); output channel o_valid/i_stall carries the
// reflectance (Q1.14) and the total reflection flag. A transaction moves
// on an edge where valid is high and stall is low.
// One transaction is accepted per cycle while o_stall is low; throughput is
// one result per cycle while i_stall is low. The depth is set by two
// 15-step square roots, a 14-step divider for the transmitted sine and two
// 15-step ratio dividers, one quotient or root bit per stage.
// The whole pipeline advances together: while the output register holds a
// result and i_stall is high, o_stall is high and every stage holds, so
// nothing is lost or repeated. The output register is the skid point.
// Synchronous active-low reset clears the valid bits only; data registers
// are not reset.
module fresnel_unpolarized_reflectance_unit
    import fresr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_fresr_in  i_data,
    output logic       o_valid,
    input  logic       i_stall,
    output t_fresr_out o_data
);

    localparam int LAT  = 65;
    localparam int NSQ  = 15;
    localparam int NDST = 14;
    localparam int NRAT = 15;

    logic            en;
    logic [LAT-1:0]  r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Stage 0: clamp cosine, square it
    t_side       r_s0_sd;
    logic [29:0] r_s0_csq;
    logic [14:0] w_c;

    assign w_c = (i_data.cos_incident > ONE) ? ONE : i_data.cos_incident;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_sd  <= '{c: w_c, n1: i_data.index_from, n2: i_data.index_to, tir: 1'b0};
            r_s0_csq <= 30'(w_c * w_c);
        end
    end

    // Incidence sine: one root bit per stage
    t_sqrt r_sa    [NSQ];
    t_side r_sa_sd [NSQ];
    t_sqrt w_sa_in [NSQ];
    t_side w_sa_sd [NSQ];

    assign w_sa_in[0] = '{rad: ONE_SQ - r_s0_csq, rem: '0, root: '0};
    assign w_sa_sd[0] = r_s0_sd;
    for (genvar g = 1; g < NSQ; g++) begin : g_sa
        assign w_sa_in[g] = r_sa[g-1];
        assign w_sa_sd[g] = r_sa_sd[g-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NSQ; i++) begin
                r_sa[i]    <= sqrt_step(w_sa_in[i]);
                r_sa_sd[i] <= w_sa_sd[i];
            end
        end
    end

    // Snell product and total reflection test
    logic [29:0] w_p;
    logic [29:0] r_p;
    t_side       r_p_sd;
    t_side       w_p_sd;

    assign w_p = 30'(r_sa[NSQ-1].root * r_sa_sd[NSQ-1].n1);
    always_comb begin
        w_p_sd     = r_sa_sd[NSQ-1];
        w_p_sd.tir = (w_p >= {1'b0, r_sa_sd[NSQ-1].n2, 14'b0});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p    <= w_p;
            r_p_sd <= w_p_sd;
        end
    end

    // Transmitted sine s_t = p / n2, one quotient bit per stage
    t_dst  r_d     [NDST];
    t_side r_d_sd  [NDST];
    t_dst  w_d_in  [NDST];
    t_side w_d_sd  [NDST];

    assign w_d_in[0] = '{rem: r_p[28:14], dvd: r_p[13:0], q: '0};
    assign w_d_sd[0] = r_p_sd;
    for (genvar g = 1; g < NDST; g++) begin : g_d
        assign w_d_in[g] = r_d[g-1];
        assign w_d_sd[g] = r_d_sd[g-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NDST; i++) begin
                r_d[i]    <= dst_step(w_d_in[i], w_d_sd[i].n2);
                r_d_sd[i] <= w_d_sd[i];
            end
        end
    end

    // Square of the transmitted sine
    logic [29:0] r_q_stsq;
    t_side       r_q_sd;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q_stsq <= 30'(r_d[NDST-1].q * r_d[NDST-1].q);
            r_q_sd   <= r_d_sd[NDST-1];
        end
    end

    // Transmitted cosine: second root
    t_sqrt r_sb    [NSQ];
    t_side r_sb_sd [NSQ];
    t_sqrt w_sb_in [NSQ];
    t_side w_sb_sd [NSQ];

    assign w_sb_in[0] = '{rad: ONE_SQ - r_q_stsq, rem: '0, root: '0};
    assign w_sb_sd[0] = r_q_sd;
    for (genvar g = 1; g < NSQ; g++) begin : g_sb
        assign w_sb_in[g] = r_sb[g-1];
        assign w_sb_sd[g] = r_sb_sd[g-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NSQ; i++) begin
                r_sb[i]    <= sqrt_step(w_sb_in[i]);
                r_sb_sd[i] <= w_sb_sd[i];
            end
        end
    end

    // Index-weighted cosines
    logic [29:0] r_m_n1c;
    logic [29:0] r_m_n2ct;
    logic [29:0] r_m_n2c;
    logic [29:0] r_m_n1ct;
    logic        r_m_tir;
    logic [14:0] w_ct;

    assign w_ct = r_sb[NSQ-1].root;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_n1c  <= 30'(r_sb_sd[NSQ-1].n1 * r_sb_sd[NSQ-1].c);
            r_m_n2ct <= 30'(r_sb_sd[NSQ-1].n2 * w_ct);
            r_m_n2c  <= 30'(r_sb_sd[NSQ-1].n2 * r_sb_sd[NSQ-1].c);
            r_m_n1ct <= 30'(r_sb_sd[NSQ-1].n1 * w_ct);
            r_m_tir  <= r_sb_sd[NSQ-1].tir;
        end
    end

    // Ratio numerators and denominators
    logic [16:0] w_x1, w_y1, w_x2, w_y2;
    t_rat        w_perp0, w_par0;

    assign w_x1 = r_m_n1c[29:IDX_FRAC];
    assign w_y1 = r_m_n2ct[29:IDX_FRAC];
    assign w_x2 = r_m_n2c[29:IDX_FRAC];
    assign w_y2 = r_m_n1ct[29:IDX_FRAC];

    always_comb begin
        w_perp0.den = {1'b0, w_x1} + {1'b0, w_y1};
        w_perp0.rem = (w_x1 >= w_y1) ? {1'b0, w_x1 - w_y1} : {1'b0, w_y1 - w_x1};
        w_perp0.q   = '0;
        w_par0.den  = {1'b0, w_x2} + {1'b0, w_y2};
        w_par0.rem  = (w_x2 >= w_y2) ? {1'b0, w_x2 - w_y2} : {1'b0, w_y2 - w_x2};
        w_par0.q    = '0;
    end

    // Two ratio dividers side by side, one quotient bit per stage
    t_rat r_ra    [NRAT];
    t_rat r_rb    [NRAT];
    logic r_r_tir [NRAT];
    t_rat w_ra_in [NRAT];
    t_rat w_rb_in [NRAT];
    logic w_r_tir [NRAT];

    assign w_ra_in[0] = w_perp0;
    assign w_rb_in[0] = w_par0;
    assign w_r_tir[0] = r_m_tir;
    for (genvar g = 1; g < NRAT; g++) begin : g_r
        assign w_ra_in[g] = r_ra[g-1];
        assign w_rb_in[g] = r_rb[g-1];
        assign w_r_tir[g] = r_r_tir[g-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < NRAT; i++) begin
                r_ra[i]    <= rat_step(w_ra_in[i], i != 0);
                r_rb[i]    <= rat_step(w_rb_in[i], i != 0);
                r_r_tir[i] <= w_r_tir[i];
            end
        end
    end

    // Squared ratios, rounded; zero denominator saturates
    logic [29:0] w_qa2, w_qb2;
    logic [14:0] r_s_perp, r_s_par;
    logic        r_s_tir;

    assign w_qa2 = 30'(r_ra[NRAT-1].q * r_ra[NRAT-1].q) + HALF;
    assign w_qb2 = 30'(r_rb[NRAT-1].q * r_rb[NRAT-1].q) + HALF;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_perp <= (r_ra[NRAT-1].den == '0) ? ONE : w_qa2[28:FRAC_BITS];
            r_s_par  <= (r_rb[NRAT-1].den == '0) ? ONE : w_qb2[28:FRAC_BITS];
            r_s_tir  <= r_r_tir[NRAT-1];
        end
    end

    // Mean of the two, forced to one on total reflection, then the output register
    logic [15:0] w_sum;
    logic [14:0] w_mean;
    t_fresr_out  r_out;

    assign w_sum  = {1'b0, r_s_perp} + {1'b0, r_s_par} + 16'd1;
    assign w_mean = (w_sum[15:1] > ONE) ? ONE : w_sum[15:1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.reflectance      <= r_s_tir ? ONE : w_mean;
            r_out.total_reflection <= r_s_tir;
        end
    end

    assign o_data = r_out;

endmodule

// ----- bench/fresnel_checker.sv -----
// Checker for the Fresnel reflectance unit: predicts each result and compares it.
module fresnel_checker
    import fresr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_stall_in,
    input  t_fresr_in  i_data,
    input  logic       i_valid_out,
    input  logic       i_stall_out,
    input  t_fresr_out i_result,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_tir_seen,
    output int         o_results_seen
);

    t_fresr_out expected_reflectances[$];

    // Integer square root, floor
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Squared amplitude ratio ((x - y)/(x + y))^2
    function automatic longint unsigned squared_ratio(longint unsigned x, longint unsigned y);
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        longint unsigned unit;
        unit = longint'(ONE);
        den  = x + y;
        num  = (x >= y) ? x - y : y - x;
        if (den == 0) return unit;
        q = (num * unit) / den;
        if (q > unit) q = unit;
        return (q * q + (unit >> 1)) >> FRAC_BITS;
    endfunction

    function automatic t_fresr_out predict_reflectance(t_fresr_in a);
        longint unsigned c, n1, n2, unit, si, st, ct, rperp, rpar, r;
        t_fresr_out      res;
        unit = longint'(ONE);
        c    = a.cos_incident;
        n1   = a.index_from;
        n2   = a.index_to;
        if (c > unit) c = unit;
        si = floor_sqrt(unit * unit - c * c);
        if (si * n1 >= unit * n2) begin
            res.reflectance      = ONE;
            res.total_reflection = 1'b1;
            return res;
        end
        st = (si * n1) / n2;
        if (st > unit) st = unit;
        ct    = floor_sqrt(unit * unit - st * st);
        rperp = squared_ratio((n1 * c) >> IDX_FRAC, (n2 * ct) >> IDX_FRAC);
        rpar  = squared_ratio((n2 * c) >> IDX_FRAC, (n1 * ct) >> IDX_FRAC);
        r     = (rperp + rpar + 1) >> 1;
        if (r > unit) r = unit;
        res.reflectance      = r[14:0];
        res.total_reflection = 1'b0;
        return res;
    endfunction

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin
        t_fresr_out want;
        if (!i_rst_n) begin
            o_fail_count   <= 0;
            o_tir_seen     <= 0;
            o_results_seen <= 0;
            o_pending      <= 0;
        end else begin
            if (i_valid && !i_stall_in)
                expected_reflectances.push_back(predict_reflectance(i_data));
            if (i_valid_out && !i_stall_out) begin
                o_results_seen <= o_results_seen + 1;
                if (expected_reflectances.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_reflectances.pop_front();
                    if (want.total_reflection) o_tir_seen <= o_tir_seen + 1;
                    if (want.reflectance !== i_result.reflectance) begin
                        $display("%0t: reflectance expected %0d actual %0d", $time,
                                 want.reflectance, i_result.reflectance);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.total_reflection !== i_result.total_reflection) begin
                        $display("%0t: total_reflection expected %0b actual %0b", $time,
                                 want.total_reflection, i_result.total_reflection);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= expected_reflectances.size();
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the Fresnel reflectance bench: stimulus, receiver stalls and the verdict.
module testbench;
    import fresr_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_fresr_in  i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b1;
    t_fresr_out o_data;
    int         fail_count, pending, tir_seen, results_seen;
    int         send_idle_pct = 20;
    int         recv_idle_pct = 61;
    bit         hold_off = 1'b0;
    int         wait_cycles;

    always #1 i_clk = ~i_clk;

    fresnel_unpolarized_reflectance_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    fresnel_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_data(i_data), .i_valid_out(o_valid), .i_stall_out(i_stall), .i_result(o_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_tir_seen(tir_seen),
        .o_results_seen(results_seen)
    );

    // Receiver stalls, changed at the falling edge
    always @(negedge i_clk) begin
        if (hold_off || !i_rst_n)
            i_stall <= 1'b1;
        else
            i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Offer one transaction and wait until it is taken; valid drops on the next idle
    task automatic send_item(logic [14:0] c, logic [14:0] n1, logic [14:0] n2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{cos_incident: c, index_from: n1, index_to: n2};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Mostly physical indices, sometimes raw bit noise including zero n2
    task automatic send_random;
        logic [14:0] c, n1, n2;
        c  = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
        n1 = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(32767, 8192));
        n2 = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(32767, 8192));
        send_item(c, n1, n2);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corners: extremes, cosine above one, zero n2, equal indices
        send_item(15'd16384, 15'd8192, 15'd8192);
        send_item(15'd0, 15'd8192, 15'd8192);
        send_item(15'd0, 15'd8192, 15'd32767);
        send_item(15'd16384, 15'd32767, 15'd8192);
        send_item(15'd32767, 15'd12288, 15'd8192);
        send_item(15'd20000, 15'd8192, 15'd12288);
        send_item(15'd8000, 15'd12288, 15'd0);
        send_item(15'd16384, 15'd0, 15'd0);
        send_item(15'd0, 15'd0, 15'd8192);
        send_item(15'd11585, 15'd12288, 15'd8192);
        send_item(15'd11585, 15'd8192, 15'd12288);
        send_item(15'd1, 15'd32767, 15'd32767);
        send_item(15'd12000, 15'd8192, 15'd13000);
        send_item(15'd3000, 15'd13000, 15'd8192);
        send_item(15'h2AAA, 15'h5555, 15'h2AAA);
        send_item(15'h5555, 15'h2AAA, 15'h5555);

        // Receiver holds off long enough to fill the pipeline
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge i_clk);
                hold_off = 1'b0;
            end
            repeat (120) send_random();
        join

        repeat (400) send_random();
        send_idle_pct = 61;
        recv_idle_pct = 20;
        repeat (400) send_random();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (400) send_random();
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (80) @(negedge i_clk);
        $display("Run covered %0d results, %0d of them total reflection,", results_seen,
                 tir_seen);
        $display("under sender/receiver idling and a long receiver hold-off.");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
